>>> src/ltq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the LRU tile index.
package ltq_pkg;

  localparam int ZOOM_W   = 8;
  localparam int SZOOM_W  = 5;
  localparam int KEY_W    = 32;
  localparam int SIZE_W   = 32;
  localparam int AGE_W    = 32;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int ME_W     = 6;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET    = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_MISS      = 3'd1,
    ST_BAD_KEY   = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_QUOTA     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  localparam logic [CFG_A_W-1:0] CFG_MAX_ENTRIES    = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_BYTE_QUOTA     = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_MAX_TILE_BYTES = 2'd2;

  localparam logic [ME_W-1:0]    RST_MAX_ENTRIES    = 6'd32;
  localparam logic [SIZE_W-1:0]  RST_BYTE_QUOTA     = 32'd1048576;
  localparam logic [SIZE_W-1:0]  RST_MAX_TILE_BYTES = 32'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LOOK,
    S_PLAN,
    S_PLAN_W,
    S_EV,
    S_EV_W,
    S_COMMIT,
    S_FREE_W,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [SZOOM_W-1:0] zoom;
    logic [KEY_W-1:0]   x;
    logic [KEY_W-1:0]   y;
    logic [SIZE_W-1:0]  bytes;
    logic [AGE_W-1:0]   age;
  } entry_t;

  typedef struct packed {
    logic en;
    logic set_used;
    logic clr_used;
    logic set_chosen;
    logic clr_chosen;
    logic wr_key;
    logic wr_bytes;
    logic wr_age;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [SIZE_W-1:0]  hit_bytes;
    logic               best_found;
    logic [AGE_W-1:0]   best_age;
    logic [SIZE_W-1:0]  best_bytes;
    logic [SZOOM_W-1:0] best_zoom;
    logic [KEY_W-1:0]   best_x;
    logic [KEY_W-1:0]   best_y;
    logic               free_found;
  } tok_t;

endpackage

>>> src/ltq_chan_if.sv
`timescale 1ns / 1ps
// Handshake channels: request, response and register write.
interface ltq_req_if;
  logic                          valid;
  logic                          ready;
  logic [ltq_pkg::KIND_W-1:0]    kind;
  logic [ltq_pkg::ZOOM_W-1:0]    tile_zoom;
  logic [ltq_pkg::KEY_W-1:0]     tile_x;
  logic [ltq_pkg::KEY_W-1:0]     tile_y;
  logic [ltq_pkg::SIZE_W-1:0]    tile_size;
  modport source(output valid, kind, tile_zoom, tile_x, tile_y, tile_size, input ready);
  modport sink(input valid, kind, tile_zoom, tile_x, tile_y, tile_size, output ready);
endinterface

interface ltq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ltq_pkg::STATUS_W-1:0]  status;
  logic                          is_victim;
  logic [ltq_pkg::SZOOM_W-1:0]   victim_zoom;
  logic [ltq_pkg::KEY_W-1:0]     victim_x;
  logic [ltq_pkg::KEY_W-1:0]     victim_y;
  logic [ltq_pkg::SIZE_W-1:0]    found_size;
  logic                          last_of_run;
  modport source(output valid, status, is_victim, victim_zoom, victim_x, victim_y,
                 found_size, last_of_run, input ready);
  modport sink(input valid, status, is_victim, victim_zoom, victim_x, victim_y,
               found_size, last_of_run, output ready);
endinterface

interface ltq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ltq_pkg::CFG_A_W-1:0]   addr;
  logic [ltq_pkg::CFG_D_W-1:0]   data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

>>> src/ltq_cell.sv
`timescale 1ns / 1ps
// One table slot: holds an entry and folds it into the passing scan token.
module ltq_cell #(
  parameter int IW  = 5,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [ltq_pkg::ZOOM_W-1:0] key_zoom,
  input  logic [ltq_pkg::KEY_W-1:0]  key_x,
  input  logic [ltq_pkg::KEY_W-1:0]  key_y,
  input  logic                    excl_en,
  input  logic [IW-1:0]           excl_idx,
  input  ltq_pkg::cmd_t           cmd,
  input  logic [IW-1:0]           cmd_idx,
  input  ltq_pkg::entry_t         wdata,
  input  ltq_pkg::tok_t           tok_in,
  input  logic [IW-1:0]           hit_idx_in,
  input  logic [IW-1:0]           best_idx_in,
  input  logic [IW-1:0]           free_idx_in,
  output ltq_pkg::tok_t           tok_out,
  output logic [IW-1:0]           hit_idx_out,
  output logic [IW-1:0]           best_idx_out,
  output logic [IW-1:0]           free_idx_out
);
  import ltq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic   used;
  logic   chosen;
  entry_t ent;

  logic   match;
  logic   cand;
  logic   take;
  logic   sel;
  tok_t   tok_next;

  assign sel   = cmd.en && (cmd_idx == MY_IDX);
  assign match = used && ({{(ZOOM_W-SZOOM_W){1'b0}}, ent.zoom} == key_zoom) &&
                 (ent.x == key_x) && (ent.y == key_y);
  assign cand  = used && !chosen && !(excl_en && (excl_idx == MY_IDX));
  assign take  = cand && (!tok_in.best_found || (ent.age < tok_in.best_age));

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && match) begin
      tok_next.hit       = 1'b1;
      tok_next.hit_bytes = ent.bytes;
    end
    if (take) begin
      tok_next.best_found = 1'b1;
      tok_next.best_age   = ent.age;
      tok_next.best_bytes = ent.bytes;
      tok_next.best_zoom  = ent.zoom;
      tok_next.best_x     = ent.x;
      tok_next.best_y     = ent.y;
    end
    if (!tok_in.free_found && !used) begin
      tok_next.free_found = 1'b1;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.hit        <= tok_next.hit;
    tok_out.hit_bytes  <= tok_next.hit_bytes;
    tok_out.best_found <= tok_next.best_found;
    tok_out.best_age   <= tok_next.best_age;
    tok_out.best_bytes <= tok_next.best_bytes;
    tok_out.best_zoom  <= tok_next.best_zoom;
    tok_out.best_x     <= tok_next.best_x;
    tok_out.best_y     <= tok_next.best_y;
    tok_out.free_found <= tok_next.free_found;
    hit_idx_out        <= (!tok_in.hit && match) ? MY_IDX : hit_idx_in;
    best_idx_out       <= take ? MY_IDX : best_idx_in;
    free_idx_out       <= (!tok_in.free_found && !used) ? MY_IDX : free_idx_in;
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= 1'b0;
      chosen <= 1'b0;
    end else begin
      if (sel && cmd.set_used) begin
        used <= 1'b1;
      end else if (sel && cmd.clr_used) begin
        used <= 1'b0;
      end
      if (cmd.en && cmd.clr_chosen) begin
        chosen <= 1'b0;
      end else if (sel && cmd.set_chosen) begin
        chosen <= 1'b1;
      end
    end
    if (sel && cmd.wr_key) begin
      ent.zoom <= wdata.zoom;
      ent.x    <= wdata.x;
      ent.y    <= wdata.y;
    end
    if (sel && cmd.wr_bytes) begin
      ent.bytes <= wdata.bytes;
    end
    if (sel && cmd.wr_age) begin
      ent.age <= wdata.age;
    end
  end

endmodule

>>> src/lru_tile_index_with_byte_quota_core.sv
`timescale 1ns / 1ps
// LRU tile index: chain of slot cells swept by a scan token, plus the op sequencer.
// A scan runs the launch, then the cells one cell a cycle, then the state that acts on its result.
// Get/remove: check, one scan, then the final beat; a bad get key or an unknown kind skips the scan.
// Put insert: lookup scan, then for each victim a planning scan and an eviction scan with its beat,
// then a free-slot scan and the final beat; update in place skips the free-slot scan.
// One request at a time, ready again in the cycle after the final beat loads; sync reset clears slots.
module lru_tile_index_with_byte_quota_core #(
  parameter int MAX_ENTRIES    = 32,
  parameter int MAX_ZOOM_LEVEL = 20
) (
  input  logic        clk,
  input  logic        rst,
  ltq_req_if.sink     req,
  ltq_rsp_if.source   rsp,
  ltq_cfg_if.sink     cfg
);
  import ltq_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > ME_W) ? CW : ME_W;

  // state and registers
  state_t state, state_next;

  logic [ME_W-1:0]    ent_cap;
  logic [SIZE_W-1:0]  quota_bytes;
  logic [SIZE_W-1:0]  tile_cap;

  logic [KIND_W-1:0]  r_kind;
  logic [ZOOM_W-1:0]  r_zoom;
  logic [KEY_W-1:0]   r_x;
  logic [KEY_W-1:0]   r_y;
  logic [SIZE_W-1:0]  r_size;

  logic [CW-1:0]      used_count;
  logic [SIZE_W-1:0]  stored_bytes;
  logic [AGE_W-1:0]   age_counter;

  logic               hit_found;
  logic [IW-1:0]      hit_idx;
  logic [SIZE_W-1:0]  hit_bytes;
  logic [SIZE_W-1:0]  prosp;
  logic [LW:0]        count;
  logic [CW-1:0]      nv;
  logic [CW-1:0]      k;
  logic               busy;

  tok_t               res;
  logic [IW-1:0]      res_hit_idx;
  logic [IW-1:0]      res_best_idx;
  logic [IW-1:0]      res_free_idx;

  logic [STATUS_W-1:0] fin_status;
  logic [SIZE_W-1:0]   fin_size;

  logic               ov;
  logic [STATUS_W-1:0] o_status;
  logic               o_is_victim;
  logic [SZOOM_W-1:0] o_zoom;
  logic [KEY_W-1:0]   o_x;
  logic [KEY_W-1:0]   o_y;
  logic [SIZE_W-1:0]  o_size;
  logic               o_last;

  // chain wiring
  tok_t               tok [MAX_ENTRIES+1];
  logic [IW-1:0]      hidx [MAX_ENTRIES+1];
  logic [IW-1:0]      bidx [MAX_ENTRIES+1];
  logic [IW-1:0]      fidx [MAX_ENTRIES+1];

  // sequencer outputs
  logic               launch;
  cmd_t               cmd;
  logic [IW-1:0]      cmd_idx;
  entry_t             wdata;
  logic               emit_victim;
  logic               emit_fin;

  // derived terms
  logic               key_ok;
  logic [LW:0]        me_ext;
  logic [LW:0]        n_ext;
  logic [LW:0]        limit;
  logic               need_evict;
  logic               can_emit;
  logic [SIZE_W-1:0]  base;
  logic [SIZE_W:0]    sum33;
  logic               ovf;

  assign key_ok   = (r_zoom <= ZOOM_W'(MAX_ZOOM_LEVEL)) &&
                    ((r_x >> r_zoom) == '0) && ((r_y >> r_zoom) == '0);
  assign me_ext   = (LW+1)'(ent_cap);
  assign n_ext    = (LW+1)'(MAX_ENTRIES);
  assign limit    = (me_ext > n_ext) ? n_ext : me_ext;
  assign need_evict = (prosp > quota_bytes) || (count > limit);
  assign can_emit = !ov || rsp.ready;
  assign base     = res.hit ? (stored_bytes - res.hit_bytes) : stored_bytes;
  assign sum33    = {1'b0, base} + {1'b0, r_size};
  assign ovf      = sum33[SIZE_W];

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid       = ov;
  assign rsp.status      = o_status;
  assign rsp.is_victim   = o_is_victim;
  assign rsp.victim_zoom = o_zoom;
  assign rsp.victim_x    = o_x;
  assign rsp.victim_y    = o_y;
  assign rsp.found_size  = o_size;
  assign rsp.last_of_run = o_last;

  // scan token entering slot 0
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch;
    hidx[0]      = '0;
    bidx[0]      = '0;
    fidx[0]      = '0;
  end

  assign wdata.zoom  = r_zoom[SZOOM_W-1:0];
  assign wdata.x     = r_x;
  assign wdata.y     = r_y;
  assign wdata.bytes = r_size;
  assign wdata.age   = age_counter;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    ltq_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .key_zoom     (r_zoom),
      .key_x        (r_x),
      .key_y        (r_y),
      .excl_en      (hit_found),
      .excl_idx     (hit_idx),
      .cmd          (cmd),
      .cmd_idx      (cmd_idx),
      .wdata        (wdata),
      .tok_in       (tok[g]),
      .hit_idx_in   (hidx[g]),
      .best_idx_in  (bidx[g]),
      .free_idx_in  (fidx[g]),
      .tok_out      (tok[g+1]),
      .hit_idx_out  (hidx[g+1]),
      .best_idx_out (bidx[g+1]),
      .free_idx_out (fidx[g+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        case (r_kind)
          KIND_GET:    state_next = key_ok ? S_LOOK : S_DONE;
          KIND_PUT:    state_next = (key_ok && (r_size <= tile_cap)) ? S_LOOK : S_DONE;
          KIND_REMOVE: state_next = S_LOOK;
          default:     state_next = S_DONE;
        endcase
      end
      S_LOOK: begin
        if (!busy) begin
          state_next = ((r_kind == KIND_PUT) && !ovf) ? S_PLAN : S_DONE;
        end
      end
      S_PLAN: begin
        if (need_evict)      state_next = S_PLAN_W;
        else if (nv == '0)   state_next = S_COMMIT;
        else                 state_next = S_EV;
      end
      S_PLAN_W: begin
        if (!busy) state_next = res.best_found ? S_PLAN : S_DONE;
      end
      S_EV: begin
        state_next = (k == nv) ? S_COMMIT : S_EV_W;
      end
      S_EV_W: begin
        if (!busy && can_emit) state_next = S_EV;
      end
      S_COMMIT: begin
        state_next = hit_found ? S_DONE : S_FREE_W;
      end
      S_FREE_W: begin
        if (!busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (can_emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: scan launch, slot commands, beats
  always_comb begin
    launch      = 1'b0;
    cmd         = '0;
    cmd_idx     = '0;
    emit_victim = 1'b0;
    emit_fin    = 1'b0;
    case (state)
      S_CHECK: begin
        launch = (state_next == S_LOOK);
      end
      S_LOOK: begin
        if (!busy) begin
          cmd_idx = res_hit_idx;
          case (r_kind)
            KIND_GET: begin
              cmd.en     = res.hit;
              cmd.wr_age = 1'b1;
            end
            KIND_REMOVE: begin
              cmd.en       = res.hit;
              cmd.clr_used = 1'b1;
            end
            KIND_PUT: begin
              cmd.en         = !ovf;
              cmd.clr_chosen = 1'b1;
            end
            default: cmd = '0;
          endcase
        end
      end
      S_PLAN: begin
        launch         = need_evict;
        cmd.en         = !need_evict;
        cmd.clr_chosen = 1'b1;
      end
      S_PLAN_W: begin
        cmd_idx        = res_best_idx;
        cmd.en         = !busy && res.best_found;
        cmd.set_chosen = 1'b1;
      end
      S_EV: begin
        launch = (k != nv);
      end
      S_EV_W: begin
        cmd_idx      = res_best_idx;
        emit_victim  = !busy && can_emit;
        cmd.en       = !busy && can_emit;
        cmd.clr_used = 1'b1;
      end
      S_COMMIT: begin
        launch       = !hit_found;
        cmd_idx      = hit_idx;
        cmd.en       = hit_found;
        cmd.wr_bytes = 1'b1;
        cmd.wr_age   = 1'b1;
      end
      S_FREE_W: begin
        cmd_idx      = res_free_idx;
        cmd.en       = !busy && res.free_found;
        cmd.set_used = 1'b1;
        cmd.wr_key   = 1'b1;
        cmd.wr_bytes = 1'b1;
        cmd.wr_age   = 1'b1;
      end
      S_DONE: begin
        emit_fin = can_emit;
      end
      default: begin
        launch = 1'b0;
      end
    endcase
  end

  // control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ent_cap      <= RST_MAX_ENTRIES;
      quota_bytes  <= RST_BYTE_QUOTA;
      tile_cap     <= RST_MAX_TILE_BYTES;
      used_count   <= '0;
      stored_bytes <= '0;
      age_counter  <= AGE_W'(1);
      busy         <= 1'b0;
      hit_found    <= 1'b0;
    end else begin
      state <= state_next;

      if (launch) begin
        busy <= 1'b1;
      end else if (tok[MAX_ENTRIES].valid) begin
        busy <= 1'b0;
      end

      if (cfg.valid) begin
        case (cfg.addr)
          CFG_MAX_ENTRIES:    ent_cap     <= cfg.data[ME_W-1:0];
          CFG_BYTE_QUOTA:     quota_bytes <= cfg.data;
          CFG_MAX_TILE_BYTES: tile_cap    <= cfg.data;
          default:            ent_cap     <= ent_cap;
        endcase
      end

      case (state)
        S_LOOK: begin
          if (!busy) begin
            hit_found <= res.hit;
            if (r_kind == KIND_GET && res.hit) begin
              age_counter <= age_counter + 1'b1;
            end
            if (r_kind == KIND_REMOVE && res.hit) begin
              stored_bytes <= stored_bytes - res.hit_bytes;
              used_count   <= used_count - 1'b1;
            end
          end
        end
        S_EV_W: begin
          if (!busy && can_emit) begin
            stored_bytes <= stored_bytes - res.best_bytes;
            used_count   <= used_count - 1'b1;
          end
        end
        S_COMMIT: begin
          if (hit_found) begin
            stored_bytes <= stored_bytes - hit_bytes + r_size;
            age_counter  <= age_counter + 1'b1;
          end
        end
        S_FREE_W: begin
          if (!busy && res.free_found) begin
            stored_bytes <= stored_bytes + r_size;
            used_count   <= used_count + 1'b1;
            age_counter  <= age_counter + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      r_kind <= req.kind;
      r_zoom <= req.tile_zoom;
      r_x    <= req.tile_x;
      r_y    <= req.tile_y;
      r_size <= req.tile_size;
    end

    if (tok[MAX_ENTRIES].valid) begin
      res          <= tok[MAX_ENTRIES];
      res_hit_idx  <= hidx[MAX_ENTRIES];
      res_best_idx <= bidx[MAX_ENTRIES];
      res_free_idx <= fidx[MAX_ENTRIES];
    end

    case (state)
      S_CHECK: begin
        fin_size <= '0;
        case (r_kind)
          KIND_GET:    fin_status <= ST_BAD_KEY;
          KIND_PUT:    fin_status <= !key_ok ? ST_BAD_KEY : ST_TOO_LARGE;
          default:     fin_status <= ST_BAD_KEY;
        endcase
      end
      S_LOOK: begin
        if (!busy) begin
          hit_idx   <= res_hit_idx;
          hit_bytes <= res.hit_bytes;
          if (r_kind == KIND_GET && res.hit) begin
            fin_size <= res.hit_bytes;
          end
          if (r_kind == KIND_PUT) begin
            // only reaches the output on a 32-bit byte total overflow
            fin_status <= ST_QUOTA;
            prosp      <= sum33[SIZE_W-1:0];
            count      <= (LW+1)'(used_count) + (res.hit ? '0 : (LW+1)'(1));
            nv         <= '0;
            k          <= '0;
          end else begin
            fin_status <= res.hit ? ST_OK : ST_MISS;
          end
        end
      end
      S_PLAN_W: begin
        if (!busy) begin
          if (res.best_found) begin
            prosp <= prosp - res.best_bytes;
            count <= count - 1'b1;
            nv    <= nv + 1'b1;
          end else begin
            fin_status <= (prosp > quota_bytes) ? ST_QUOTA : ST_FULL;
          end
        end
      end
      S_EV_W: begin
        if (!busy && can_emit) k <= k + 1'b1;
      end
      S_COMMIT: begin
        fin_status <= ST_OK;
      end
      S_FREE_W: begin
        if (!busy) fin_status <= res.free_found ? ST_OK : ST_FULL;
      end
      default: begin
        fin_size <= fin_size;
      end
    endcase
  end

  // output register: one beat held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit_victim || emit_fin) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
    if (emit_victim) begin
      o_status    <= ST_OK;
      o_is_victim <= 1'b1;
      o_zoom      <= res.best_zoom;
      o_x         <= res.best_x;
      o_y         <= res.best_y;
      o_size      <= '0;
      o_last      <= 1'b0;
    end else if (emit_fin) begin
      o_status    <= fin_status;
      o_is_victim <= 1'b0;
      o_zoom      <= '0;
      o_x         <= '0;
      o_y         <= '0;
      o_size      <= fin_size;
      o_last      <= 1'b1;
    end
  end

endmodule
